### sv/sobg_pkg.sv
package sobg_pkg;

  localparam int GRAD_W = 11;
  localparam int MAG_W = 11;
  localparam int DIR_W = 13;
  localparam int REG_W = 11;
  localparam int ROW_W = 11;
  localparam int MIN_DIM = 3;
  localparam int HEIGHT_LIMIT = 1024;

  localparam logic [REG_W-1:0] WIDTH_RESET = 11'd640;
  localparam logic [REG_W-1:0] HEIGHT_RESET = 11'd480;

  // register indexes on the write port
  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // CORDIC and square root
  localparam int CORDIC_STEPS = 48;
  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam int XY_SHIFT = 40;
  localparam int Q_BITS = 56;
  localparam int ANGLE_FRAC_BITS = 10;
  localparam int XY_W = 54;
  localparam int Z_W = 60;
  localparam int SQ_STEPS = 11;
  localparam int SQ_W = 21;
  localparam int ROOT_W = 22;

  typedef struct packed {
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic                     last;
  } grad_word_t;

  // atan(2^-sh) in Q56 from the truncated Taylor series
  function automatic logic [63:0] atan_pow2(input int sh);
    logic [63:0] p;
    logic [63:0] sum;
    int k;
    p = 64'd1 << (Q_BITS - sh);
    sum = p;
    for (k = 1; k < 64; k++) begin
      p = (p >> sh) >> sh;
      if (k[0]) sum = sum - p / 64'(2 * k + 1);
      else sum = sum + p / 64'(2 * k + 1);
    end
    return sum;
  endfunction

  // atan(1/3) in Q56, same series
  function automatic logic [63:0] atan_third();
    logic [63:0] p;
    logic [63:0] sum;
    int k;
    p = (64'd1 << Q_BITS) / 64'd3;
    sum = p;
    for (k = 1; k < 64; k++) begin
      p = (p / 64'd3) / 64'd3;
      if (k[0]) sum = sum - p / 64'(2 * k + 1);
      else sum = sum + p / 64'(2 * k + 1);
    end
    return sum;
  endfunction

  function automatic logic [Z_W-1:0] atan_entry(input int i);
    logic [63:0] v;
    if (i == 0) v = atan_pow2(1) + atan_third();
    else v = atan_pow2(i);
    return Z_W'(v);
  endfunction

  localparam logic [Z_W-1:0] PI_Q = Z_W'((atan_pow2(1) + atan_third()) << 2);

endpackage

### sv/sobel_gradient_mag_dir_core.sv
// Sobel 3x3 gradient, magnitude and direction on a raster pixel stream.
// The front takes one pixel word per cycle while full is low; results come 1 row + 1 pixel behind.
// Each result passes through the back end as load, 48 CORDIC rotations and round;
// the back end takes no new word until the current result has left for the output.
// Synchronous active-high reset clears counters, queue and registers (640x480).
module sobel_gradient_mag_dir_core
  import sobg_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic                     operation,
  input  logic [7:0]               pixel,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [GRAD_W-1:0] grad_x,
  output logic signed [GRAD_W-1:0] grad_y,
  output logic [MAG_W-1:0]         magnitude,
  output logic signed [DIR_W-1:0]  direction,
  output logic                     last_of_frame,
  input  logic                     write_enable,
  input  logic                     write_index,
  input  logic [REG_W-1:0]         write_data
);

  logic              q_push;
  grad_word_t        q_in;
  logic              q_pop;
  grad_word_t        q_out;
  logic              q_empty;
  logic [QCNT_W-1:0] q_count;

  sobg_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .operation(operation),
    .pixel(pixel),
    .write_enable(write_enable),
    .write_index(write_index),
    .write_data(write_data),
    .queue_count(q_count),
    .q_push(q_push),
    .q_word(q_in)
  );

  sobg_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .wr(q_push),
    .wr_word(q_in),
    .rd(q_pop),
    .rd_word(q_out),
    .empty(q_empty),
    .count(q_count)
  );

  sobg_back u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_word(q_out),
    .q_pop(q_pop),
    .empty(empty),
    .pop(pop),
    .grad_x(grad_x),
    .grad_y(grad_y),
    .magnitude(magnitude),
    .direction(direction),
    .last_of_frame(last_of_frame)
  );

endmodule

### sv/sobg_front.sv
module sobg_front
  import sobg_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               operation,
  input  logic [7:0]         pixel,
  input  logic               write_enable,
  input  logic               write_index,
  input  logic [REG_W-1:0]   write_data,
  input  logic [QCNT_W-1:0]  queue_count,
  output logic               q_push,
  output grad_word_t         q_word
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WV_W = ($clog2(MAX_WIDTH + 1) > REG_W) ? $clog2(MAX_WIDTH + 1) : REG_W;

  logic [REG_W-1:0] image_width;
  logic [REG_W-1:0] image_height;
  logic [COL_W-1:0] in_column;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] out_column;
  logic [ROW_W-2:0] out_row;

  logic [WV_W-1:0]  w_ext;
  logic [WV_W-1:0]  w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [WV_W-1:0]  col_plus;
  logic [WV_W-1:0]  ocol_plus;
  logic [ROW_W-1:0] orow_plus;
  logic             active;
  logic             in_frame;
  logic             take;
  logic             emit;
  logic             last;
  logic [7:0]       pix_a;

  // B stage
  logic             b_valid;
  logic             b_emit;
  logic             b_last;
  logic             b_rv0;
  logic             b_rv2;
  logic             b_cv0;
  logic             b_cv2;
  logic [7:0]       b_pix;
  logic [COL_W-1:0] b_col;
  logic [7:0]       top_rd;
  logic [7:0]       mid_rd;
  logic [7:0]       top_mem [MAX_WIDTH];
  logic [7:0]       mid_mem [MAX_WIDTH];
  logic [7:0]       col_a [3];
  logic [7:0]       col_b [3];
  logic [7:0]       e [3][3];
  logic signed [GRAD_W:0] lsum;
  logic signed [GRAD_W:0] rsum;
  logic signed [GRAD_W:0] tsum;
  logic signed [GRAD_W:0] bsum;
  logic             b_push;
  logic [QCNT_W:0]  fill;

  always_comb begin
    w_ext = WV_W'(image_width);
    if (w_ext > WV_W'(MAX_WIDTH)) w_eff = WV_W'(MAX_WIDTH);
    else if (w_ext < WV_W'(MIN_DIM)) w_eff = WV_W'(MIN_DIM);
    else w_eff = w_ext;
    if (image_height > ROW_W'(HEIGHT_LIMIT)) h_eff = ROW_W'(HEIGHT_LIMIT);
    else if (image_height < ROW_W'(MIN_DIM)) h_eff = ROW_W'(MIN_DIM);
    else h_eff = image_height;
  end

  assign col_plus = WV_W'(in_column) + WV_W'(1);
  assign ocol_plus = WV_W'(out_column) + WV_W'(1);
  assign orow_plus = ROW_W'(out_row) + ROW_W'(1);
  assign in_frame = in_row < h_eff;
  assign active = push && !full;
  // drop a flush word while the frame still expects pixels
  assign take = active && !(operation && in_frame);
  assign pix_a = in_frame ? pixel : 8'd0;
  assign emit = (in_row >= ROW_W'(2)) || (in_row == ROW_W'(1) && in_column != '0);
  assign last = (orow_plus >= h_eff) && (ocol_plus >= w_eff);

  assign b_push = b_valid && b_emit;
  assign fill = (QCNT_W + 1)'(queue_count) + (QCNT_W + 1)'(b_push);
  assign full = fill >= (QCNT_W + 1)'(QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      in_column <= '0;
      in_row <= '0;
      out_column <= '0;
      out_row <= '0;
    end else if (write_enable) begin
      if (write_index == REG_IMAGE_WIDTH) image_width <= write_data;
      else image_height <= write_data;
      in_column <= '0;
      in_row <= '0;
      out_column <= '0;
      out_row <= '0;
    end else if (take) begin
      if (emit && last) begin
        in_column <= '0;
        in_row <= '0;
        out_column <= '0;
        out_row <= '0;
      end else begin
        if (col_plus >= w_eff) begin
          in_column <= '0;
          in_row <= in_row + ROW_W'(1);
        end else begin
          in_column <= COL_W'(col_plus);
        end
        if (emit) begin
          if (ocol_plus >= w_eff) begin
            out_column <= '0;
            out_row <= out_row + (ROW_W - 1)'(1);
          end else begin
            out_column <= COL_W'(ocol_plus);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else b_valid <= take;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b_emit <= emit;
      b_last <= last;
      b_rv0 <= out_row != '0;
      b_rv2 <= orow_plus < h_eff;
      b_cv0 <= out_column != '0;
      b_cv2 <= ocol_plus < w_eff;
      b_pix <= pix_a;
      b_col <= in_column;
    end
  end

  // line stores: read old data, then shift rows up one
  always_ff @(posedge clk) begin
    if (take) begin
      mid_rd <= mid_mem[in_column];
      mid_mem[in_column] <= pix_a;
    end
  end

  always_ff @(posedge clk) begin
    if (take) top_rd <= top_mem[in_column];
    if (b_valid) top_mem[b_col] <= mid_rd;
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      col_a <= col_b;
      col_b[0] <= top_rd;
      col_b[1] <= mid_rd;
      col_b[2] <= b_pix;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      e[r][0] = col_a[r];
      e[r][1] = col_b[r];
    end
    e[0][2] = top_rd;
    e[1][2] = mid_rd;
    e[2][2] = b_pix;
    for (int c = 0; c < 3; c++) begin
      if (!b_rv0) e[0][c] = 8'd0;
      if (!b_rv2) e[2][c] = 8'd0;
    end
    for (int r = 0; r < 3; r++) begin
      if (!b_cv0) e[r][0] = 8'd0;
      if (!b_cv2) e[r][2] = 8'd0;
    end
    lsum = $signed({4'd0, e[0][0]}) + $signed({3'd0, e[1][0], 1'b0}) + $signed({4'd0, e[2][0]});
    rsum = $signed({4'd0, e[0][2]}) + $signed({3'd0, e[1][2], 1'b0}) + $signed({4'd0, e[2][2]});
    tsum = $signed({4'd0, e[0][0]}) + $signed({3'd0, e[0][1], 1'b0}) + $signed({4'd0, e[0][2]});
    bsum = $signed({4'd0, e[2][0]}) + $signed({3'd0, e[2][1], 1'b0}) + $signed({4'd0, e[2][2]});
  end

  assign q_push = b_push;
  assign q_word.grad_x = GRAD_W'(rsum - lsum);
  assign q_word.grad_y = GRAD_W'(bsum - tsum);
  assign q_word.last = b_last;

endmodule

### sv/sobg_fifo.sv
module sobg_fifo
  import sobg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  grad_word_t        wr_word,
  input  logic              rd,
  output grad_word_t        rd_word,
  output logic              empty,
  output logic [QCNT_W-1:0] count
);

  grad_word_t        mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign empty = count == '0;
  assign rd_word = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= wr_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (rd) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (wr && !rd) count <= count + QCNT_W'(1);
      else if (rd && !wr) count <= count - QCNT_W'(1);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (wr && !rd) |-> (count < QCNT_W'(QUEUE_DEPTH)))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd |-> !empty)
    else $error("queue underflow");
`endif

endmodule

### sv/sobg_back.sv
module sobg_back
  import sobg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_empty,
  input  grad_word_t               q_word,
  output logic                     q_pop,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [GRAD_W-1:0] grad_x,
  output logic signed [GRAD_W-1:0] grad_y,
  output logic [MAG_W-1:0]         magnitude,
  output logic signed [DIR_W-1:0]  direction,
  output logic                     last_of_frame
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN = 2'd1;
  localparam logic [1:0] ST_FIN = 2'd2;

  logic [1:0]               state;
  logic [STEP_W-1:0]        step;
  logic                     out_valid;
  grad_word_t               cur;
  logic                     zero;
  logic signed [XY_W-1:0]   x;
  logic signed [XY_W-1:0]   y;
  logic signed [Z_W-1:0]    z;
  logic [SQ_W-1:0]          sq_rem;
  logic [ROOT_W-1:0]        sq_root;
  logic signed [Z_W-1:0]    atan_tab [CORDIC_STEPS];

  logic signed [XY_W-1:0]   gxe;
  logic signed [XY_W-1:0]   gye;
  logic signed [2*GRAD_W-1:0] sq_x;
  logic signed [2*GRAD_W-1:0] sq_y;
  logic [2*GRAD_W:0]        sq_sum;
  logic signed [XY_W-1:0]   xd;
  logic signed [XY_W-1:0]   yd;
  logic                     y_pos;
  logic [ROOT_W-1:0]        sq_bit;
  logic [ROOT_W-1:0]        sq_trial;
  logic [Z_W-1:0]           zmag;
  logic [Z_W-1:0]           zrnd;
  logic [Z_W-1:0]           zlim;
  logic [Z_W-1:0]           zsat;
  logic                     zneg;
  logic [MAG_W-1:0]         root_n;
  logic                     fin_go;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_tab
    assign atan_tab[g] = atan_entry(g);
  end

  assign q_pop = (state == ST_IDLE) && !q_empty;
  assign fin_go = (state == ST_FIN) && (!out_valid || pop);
  assign empty = !out_valid;

  always_comb begin
    gxe = XY_W'(q_word.grad_x) <<< XY_SHIFT;
    gye = XY_W'(q_word.grad_y) <<< XY_SHIFT;
    sq_x = q_word.grad_x * q_word.grad_x;
    sq_y = q_word.grad_y * q_word.grad_y;
    sq_sum = (2 * GRAD_W + 1)'($unsigned(sq_x)) + (2 * GRAD_W + 1)'($unsigned(sq_y));
  end

  // one CORDIC rotation and one square-root trial; y shift truncates toward zero, x stays non-negative
  always_comb begin
    y_pos = !y[XY_W-1] && (y != '0);
    xd = x >>> step;
    if (y[XY_W-1]) yd = -((-y) >>> step);
    else yd = y >>> step;
    sq_bit = ROOT_W'(1) << (5'(2 * (SQ_STEPS - 1)) - {step[3:0], 1'b0});
    sq_trial = sq_root + sq_bit;
  end

  always_comb begin
    zneg = z[Z_W-1];
    zmag = zneg ? $unsigned(-z) : $unsigned(z);
    zrnd = (zmag + (Z_W'(1) << (Q_BITS - 1 - ANGLE_FRAC_BITS))) >> (Q_BITS - ANGLE_FRAC_BITS);
    zlim = zneg ? Z_W'(1 << (DIR_W - 1)) : Z_W'((1 << (DIR_W - 1)) - 1);
    zsat = (zrnd > zlim) ? zlim : zrnd;
    root_n = sq_root[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_RUN;
            step <= '0;
          end
        end
        ST_RUN: begin
          if (step == STEP_W'(CORDIC_STEPS - 1)) state <= ST_FIN;
          else step <= step + STEP_W'(1);
        end
        ST_FIN: begin
          if (fin_go) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_word;
      zero <= (q_word.grad_x == '0) && (q_word.grad_y == '0);
      sq_rem <= SQ_W'(sq_sum);
      sq_root <= '0;
      if (q_word.grad_x[GRAD_W-1]) begin
        x <= -gxe;
        y <= -gye;
        z <= q_word.grad_y[GRAD_W-1] ? -$signed(PI_Q) : $signed(PI_Q);
      end else begin
        x <= gxe;
        y <= gye;
        z <= '0;
      end
    end else if (state == ST_RUN) begin
      if (y_pos) begin
        x <= x + yd;
        y <= y - xd;
        z <= z + atan_tab[step];
      end else begin
        x <= x - yd;
        y <= y + xd;
        z <= z - atan_tab[step];
      end
      if (step < STEP_W'(SQ_STEPS)) begin
        if (ROOT_W'(sq_rem) >= sq_trial) begin
          sq_rem <= SQ_W'(ROOT_W'(sq_rem) - sq_trial);
          sq_root <= (sq_root >> 1) + sq_bit;
        end else begin
          sq_root <= sq_root >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (fin_go) out_valid <= 1'b1;
    else if (pop) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      grad_x <= cur.grad_x;
      grad_y <= cur.grad_y;
      last_of_frame <= cur.last;
      // round to nearest: bump when the remainder passes the root
      magnitude <= (ROOT_W'(sq_rem) > ROOT_W'(root_n)) ? root_n + MAG_W'(1) : root_n;
      if (zero) direction <= '0;
      else if (zneg) direction <= -$signed(DIR_W'(zsat));
      else direction <= $signed(DIR_W'(zsat));
    end
  end

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (step < STEP_W'(CORDIC_STEPS)))
    else $error("cordic step out of range");
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && out_valid && !pop) |=> (state == ST_FIN))
    else $error("result dropped while output busy");
`endif

endmodule
